// File: design/lole_pkg.sv
// Package for the linked order list engine.
// Holds action, status and sequencer state codes and the fixed field widths.
// No dependencies.
`default_nettype none

package lole_pkg;

  localparam int ITEM_W   = 11;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;
  localparam int N_JOINS  = 4;
  localparam int JOIN_CW  = $clog2(N_JOINS);

  localparam logic [ITEM_W-1:0] ITEM_COUNT_RST = ITEM_W'(1024);

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT    = 3'd0,
    ACT_LEFT    = 3'd1,
    ACT_RIGHT   = 3'd2,
    ACT_SWAP    = 3'd3,
    ACT_REVERSE = 3'd4,
    ACT_QUERY   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_APPLIED   = 2'd0,
    STS_NO_CHANGE = 2'd1,
    STS_INVALID   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_JOIN,
    ST_INIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: design/lole_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module lole_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: design/linked_order_list_engine.sv
// Linked order list engine: top level, sequencer and link update logic.
// Depends on lole_pkg and lole_ram (two link memories, before and after).
// Sequence per request: ST_CALC, then ST_DONE for query, reverse, invalid and
//   in-place moves; a move or swap passes ST_JOIN first (four link writes, one per
//   cycle, bound by the single write port of each link memory); init runs ST_INIT.
// Only one request is in flight at a time. Reset (rst_n, synchronous) clears
//   the sequencer, orientation and list length; link memories are not cleared.
`default_nettype none

module linked_order_list_engine
  import lole_pkg::*;
#(
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [ITEM_W-1:0]   in_first_item,
  input  wire logic [ITEM_W-1:0]   in_second_item,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [ITEM_W-1:0]   out_left_item,
  output logic      [ITEM_W-1:0]   out_right_item,
  // configuration port
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [PADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_W-1:0]    cfg_pwdata,
  output logic      [CFG_W-1:0]    cfg_prdata,
  output logic                     cfg_pready
);

  // Link index width covers entries 0..MAX_ITEMS; compare width covers both
  // link indices and the request fields.
  localparam int LW = $clog2(MAX_ITEMS + 1);
  localparam int CW = (LW > ITEM_W) ? LW : ITEM_W;
  localparam logic [CW-1:0]      MAX_C     = CW'(MAX_ITEMS);
  localparam logic [JOIN_CW-1:0] JOIN_LAST = JOIN_CW'(N_JOINS - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  action_t             act_r, act_nxt;
  logic [ITEM_W-1:0]   x_r, x_nxt;
  logic [ITEM_W-1:0]   y_r, y_nxt;
  logic [ITEM_W-1:0]   item_count_r, item_count_nxt;
  logic [LW-1:0]       list_len_r, list_len_nxt;
  logic                fwd_r, fwd_nxt;
  logic [LW-1:0]       join_a_r [N_JOINS];
  logic [LW-1:0]       join_a_nxt [N_JOINS];
  logic [LW-1:0]       join_b_r [N_JOINS];
  logic [LW-1:0]       join_b_nxt [N_JOINS];
  logic [JOIN_CW-1:0]  join_cnt_r, join_cnt_nxt;
  logic [LW-1:0]       init_idx_r, init_idx_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [ITEM_W-1:0]   res_left_r, res_left_nxt;
  logic [ITEM_W-1:0]   res_right_r, res_right_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ITEM_W-1:0]   out_left_r, out_left_nxt;
  logic [ITEM_W-1:0]   out_right_r, out_right_nxt;

  // ---------------------------------------------------------------------------
  // Link memories: entry 0 is the sentinel closing the ring.
  // Port a reads x, port b reads y; data arrives in ST_CALC.
  // ---------------------------------------------------------------------------
  logic          ram_we;
  logic [LW-1:0] aft_waddr, aft_wdata, bef_waddr, bef_wdata;
  logic [LW-1:0] rd_addr_x, rd_addr_y;
  logic [LW-1:0] px, nx, py, ny;

  lole_ram #(.WIDTH(LW), .DEPTH(MAX_ITEMS + 1)) u_bef_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (bef_waddr),
    .wdata   (bef_wdata),
    .raddr_a (rd_addr_x),
    .raddr_b (rd_addr_y),
    .rdata_a (px),
    .rdata_b (py)
  );

  lole_ram #(.WIDTH(LW), .DEPTH(MAX_ITEMS + 1)) u_aft_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (aft_waddr),
    .wdata   (aft_wdata),
    .raddr_a (rd_addr_x),
    .raddr_b (rd_addr_y),
    .rdata_a (nx),
    .rdata_b (ny)
  );

  // ---------------------------------------------------------------------------
  // Compute stage: classify the request from the links of x and y and build
  // the join list (after[a] = b, before[b] = a) plus the reported neighbors.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] xc, yc, lenc, ic, n_c;
  logic [LW-1:0] xa, ya, n_l;
  logic          x_ok, y_ok, pair_ok, dir_left, no_change, sw, adjacent;
  logic [LW-1:0] sa, sb, psa, nsa, psb, nsb;
  logic          edit_go, rep_ok, fwd_calc;
  status_t       calc_status;
  logic [LW-1:0] rep_l, rep_r;
  logic [LW-1:0] ca [N_JOINS];
  logic [LW-1:0] cb [N_JOINS];

  always_comb begin
    xc   = CW'(x_r);
    yc   = CW'(y_r);
    lenc = CW'(list_len_r);
    xa   = LW'(x_r);
    ya   = LW'(y_r);
    x_ok = (xc != '0) && (xc <= lenc);
    y_ok = (yc != '0) && (yc <= lenc);
    pair_ok = x_ok && y_ok && (x_r != y_r);

    // Under reversal left and right moves trade roles.
    dir_left  = fwd_r ? (act_r == ACT_LEFT) : (act_r == ACT_RIGHT);
    no_change = dir_left ? (xa == py) : (xa == ny);

    // Swap: relabel so that sa comes before sb when the two are adjacent.
    sw       = (ny == xa);
    sa       = sw ? ya : xa;
    sb       = sw ? xa : ya;
    psa      = sw ? py : px;
    nsa      = sw ? ny : nx;
    psb      = sw ? px : py;
    nsb      = sw ? nx : ny;
    adjacent = (nsa == sb);

    // Clamp the init count into 1..MAX_ITEMS.
    ic = CW'(item_count_r);
    if (ic == '0) begin
      n_c = CW'(1);
    end else if (ic > MAX_C) begin
      n_c = MAX_C;
    end else begin
      n_c = ic;
    end
    n_l = LW'(n_c);

    calc_status = STS_APPLIED;
    edit_go     = 1'b0;
    rep_ok      = 1'b0;
    rep_l       = px;
    rep_r       = nx;
    fwd_calc    = fwd_r;
    for (int j = 0; j < N_JOINS; j++) begin
      ca[j] = px;
      cb[j] = nx;
    end

    case (act_r) inside
      ACT_INIT: begin
        fwd_calc = 1'b1;
        rep_ok   = (xc != '0) && (xc <= n_c);
        rep_l    = xa - LW'(1);
        rep_r    = (xa == n_l) ? '0 : xa + LW'(1);
      end
      ACT_REVERSE: begin
        fwd_calc = ~fwd_r;
        rep_ok   = x_ok;
      end
      ACT_LEFT, ACT_RIGHT: begin
        if (!pair_ok) begin
          calc_status = STS_INVALID;
        end else begin
          rep_ok = 1'b1;
          if (no_change) begin
            calc_status = STS_NO_CHANGE;
          end else begin
            edit_go = 1'b1;
            // Unlink x, then splice it in; the last join repeats harmlessly.
            if (dir_left) begin
              ca[1] = py; cb[1] = xa;
              ca[2] = xa; cb[2] = ya;
              rep_l = py;
              rep_r = ya;
            end else begin
              ca[1] = ya; cb[1] = xa;
              ca[2] = xa; cb[2] = ny;
              rep_l = ya;
              rep_r = ny;
            end
            ca[3] = ca[2];
            cb[3] = cb[2];
          end
        end
      end
      ACT_SWAP: begin
        if (!pair_ok) begin
          calc_status = STS_INVALID;
        end else begin
          rep_ok  = 1'b1;
          edit_go = 1'b1;
          ca[0] = psa; cb[0] = sb;
          if (adjacent) begin
            ca[1] = sb; cb[1] = sa;
            ca[2] = sa; cb[2] = nsb;
            ca[3] = sa; cb[3] = nsb;
            rep_l = sw ? psa : sb;
            rep_r = sw ? sa  : nsb;
          end else begin
            ca[1] = sb;  cb[1] = nsa;
            ca[2] = psb; cb[2] = sa;
            ca[3] = sa;  cb[3] = nsb;
            rep_l = sw ? psa : psb;
            rep_r = sw ? nsa : nsb;
          end
        end
      end
      ACT_QUERY: begin
        rep_ok      = x_ok;
        calc_status = x_ok ? STS_APPLIED : STS_INVALID;
      end
      default: begin
        // unused action codes behave as query
        rep_ok      = x_ok;
        calc_status = x_ok ? STS_APPLIED : STS_INVALID;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (act_r == ACT_INIT) begin
          state_nxt = ST_INIT;
        end else if (edit_go) begin
          state_nxt = ST_JOIN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_JOIN: begin
        if (join_cnt_r == JOIN_LAST) state_nxt = ST_DONE;
      end
      ST_INIT: begin
        if (init_idx_r == list_len_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs and memory write port
  // ---------------------------------------------------------------------------
  logic cfg_wr;

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    rd_addr_x = LW'(in_first_item);
    rd_addr_y = LW'(in_second_item);
    ram_we    = 1'b0;
    aft_waddr = join_a_r[join_cnt_r];
    aft_wdata = join_b_r[join_cnt_r];
    bef_waddr = join_b_r[join_cnt_r];
    bef_wdata = join_a_r[join_cnt_r];
    unique case (state_r)
      ST_JOIN: begin
        ram_we = 1'b1;
      end
      ST_INIT: begin
        // sweep entries 0..n laying out the ring 0,1,..,n
        ram_we    = 1'b1;
        aft_waddr = init_idx_r;
        bef_waddr = init_idx_r;
        if (init_idx_r == '0) begin
          aft_wdata = LW'(1);
          bef_wdata = list_len_r;
        end else begin
          aft_wdata = (init_idx_r == list_len_r) ? '0 : init_idx_r + LW'(1);
          bef_wdata = init_idx_r - LW'(1);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase

    cfg_pready = 1'b1;
    cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
    cfg_prdata = cfg_paddr[2] ? '0 : CFG_W'(item_count_r);

    out_valid      = out_valid_r;
    out_status     = out_status_r;
    out_left_item  = out_left_r;
    out_right_item = out_right_r;
  end

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    act_nxt        = act_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    item_count_nxt = cfg_wr ? cfg_pwdata[ITEM_W-1:0] : item_count_r;
    list_len_nxt   = list_len_r;
    fwd_nxt        = fwd_r;
    join_a_nxt     = join_a_r;
    join_b_nxt     = join_b_r;
    join_cnt_nxt   = join_cnt_r;
    init_idx_nxt   = init_idx_r;
    res_status_nxt = res_status_r;
    res_left_nxt   = res_left_r;
    res_right_nxt  = res_right_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;

    // capture the request
    if (in_valid && in_ready) begin
      act_nxt = action_t'(in_action);
      x_nxt   = in_first_item;
      y_nxt   = in_second_item;
    end

    if (state_r == ST_CALC) begin
      fwd_nxt        = fwd_calc;
      join_a_nxt     = ca;
      join_b_nxt     = cb;
      join_cnt_nxt   = '0;
      init_idx_nxt   = '0;
      res_status_nxt = calc_status;
      if (act_r == ACT_INIT) list_len_nxt = n_l;
      if (rep_ok) begin
        res_left_nxt  = ITEM_W'(fwd_calc ? rep_l : rep_r);
        res_right_nxt = ITEM_W'(fwd_calc ? rep_r : rep_l);
      end else begin
        res_left_nxt  = '0;
        res_right_nxt = '0;
      end
    end

    if (state_r == ST_JOIN) join_cnt_nxt = join_cnt_r + JOIN_CW'(1);
    if (state_r == ST_INIT) init_idx_nxt = init_idx_r + LW'(1);

    // advance the result into the output register
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_left_nxt   = res_left_r;
      out_right_nxt  = res_right_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      item_count_r <= ITEM_COUNT_RST;
      list_len_r   <= '0;
      fwd_r        <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      item_count_r <= item_count_nxt;
      list_len_r   <= list_len_nxt;
      fwd_r        <= fwd_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    join_a_r     <= join_a_nxt;
    join_b_r     <= join_b_nxt;
    join_cnt_r   <= join_cnt_nxt;
    init_idx_r   <= init_idx_nxt;
    res_status_r <= res_status_nxt;
    res_left_r   <= res_left_nxt;
    res_right_r  <= res_right_nxt;
    out_status_r <= out_status_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A new request never samples the memories while a link write is in flight.
  a_no_accept_during_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !ram_we)
    else $error("request accepted while link memories are written");

  // Finishing a request always leaves a result in the output register.
  a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished request produced no result");

  // Link edits only touch entries inside the current ring.
  a_join_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JOIN) |-> (CW'(aft_waddr) <= CW'(list_len_r)
                              && CW'(bef_waddr) <= CW'(list_len_r)))
    else $error("link write outside the list");

  // The latched list length stays within the memory depth.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(list_len_r) <= MAX_C)
    else $error("list length beyond capacity");

endmodule

`default_nettype wire
